>>> sv/rpf_pkg.sv
`default_nettype none

package rpf_pkg;

    // Ring geometry and frame framing
    localparam int FIFO_DEPTH   = 128;
    localparam int HEADER_BYTES = 9;
    localparam int FCS_BYTES    = 2;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = PTR_W + 1;

    // Field widths
    localparam int DATA_W  = 8;
    localparam int LEN_W   = 7;
    localparam int FILL_W  = 7;
    localparam int LQ_W    = 8;

    typedef enum logic [1:0] {
        OP_FRAME_BYTE = 2'd0,
        OP_READ       = 2'd1,
        OP_PEEK       = 2'd2,
        OP_FLUSH      = 2'd3
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic fetch_done;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_fetch;
    } status_t;

endpackage

`default_nettype wire

>>> sv/rpf_in_if.sv
`default_nettype none

interface rpf_in_if;
    logic              valid;
    logic              ready;
    rpf_pkg::op_t      op;
    logic [7:0]        rx_byte;
    logic [6:0]        frame_length;
    logic [6:0]        byte_index;
    logic              fcs_bad;
    logic [7:0]        link_quality;

    modport source (
        output valid, op, rx_byte, frame_length, byte_index, fcs_bad, link_quality,
        input  ready
    );

    modport sink (
        input  valid, op, rx_byte, frame_length, byte_index, fcs_bad, link_quality,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/rpf_out_if.sv
`default_nettype none

interface rpf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       read_valid;
    logic [6:0] fill_count;
    logic [7:0] last_quality;

    modport source (
        output valid, read_data, read_valid, fill_count, last_quality,
        input  ready
    );

    modport sink (
        input  valid, read_data, read_valid, fill_count, last_quality,
        output ready
    );
endinterface

`default_nettype wire

>>> sv/rpf_ram.sv
`default_nettype none

module rpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/rpf_ctrl.sv
`default_nettype none

module rpf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire rpf_pkg::status_t status,
    output rpf_pkg::cmd_t         cmd
);

    import rpf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_SEND  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = (state_reg == ST_SEND);
    assign cmd.accept     = in_ready && in_valid;
    assign cmd.fetch_done = (state_reg == ST_FETCH);

    // Sequence: take item, wait on ring read if needed, hold result
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.need_fetch ? ST_FETCH : ST_SEND;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/rpf_datapath.sv
`default_nettype none

module rpf_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rpf_pkg::cmd_t               cmd,
    output rpf_pkg::status_t                 status,
    input  wire rpf_pkg::op_t                op,
    input  wire logic [rpf_pkg::DATA_W-1:0]  rx_byte,
    input  wire logic [rpf_pkg::LEN_W-1:0]   frame_length,
    input  wire logic [rpf_pkg::LEN_W-1:0]   byte_index,
    input  wire logic                        fcs_bad,
    input  wire logic [rpf_pkg::LQ_W-1:0]    link_quality,
    output logic      [rpf_pkg::DATA_W-1:0]  read_data,
    output logic                             read_valid,
    output logic      [rpf_pkg::FILL_W-1:0]  fill_count,
    output logic      [rpf_pkg::LQ_W-1:0]    last_quality
);

    import rpf_pkg::*;

    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);
    localparam logic [7:0]       HDR       = 8'(HEADER_BYTES);
    localparam logic [7:0]       FCS       = 8'(FCS_BYTES);

    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic              stopped_reg, stopped_next;
    logic [LQ_W-1:0]   qual_reg, qual_next;

    logic [DATA_W-1:0] res_data_reg;
    logic              res_valid_reg;
    logic [FILL_W-1:0] res_fill_reg;
    logic [LQ_W-1:0]   res_qual_reg;

    logic [DATA_W-1:0] ram_rd_data;

    logic [PTR_W-1:0]  wp_inc, rp_inc;
    logic              empty, full;
    logic [7:0]        len8, idx8;
    logic              in_frame, frame_start, good, payload, stopped_eff;
    logic              want_queue, do_write, is_fetch_op;
    logic [CNT_W-1:0]  wp_wide, rp_wide, fill_wide;

    // Pointer wrap and occupancy
    assign wp_inc = (wp_reg == LAST_SLOT) ? '0 : wp_reg + 1'b1;
    assign rp_inc = (rp_reg == LAST_SLOT) ? '0 : rp_reg + 1'b1;
    assign empty  = (wp_reg == rp_reg);
    assign full   = (wp_inc == rp_reg);

    // Classify the frame byte
    assign len8        = {1'b0, frame_length};
    assign idx8        = {1'b0, byte_index};
    assign in_frame    = (idx8 < len8);
    assign frame_start = (byte_index == '0);
    assign good        = in_frame && !fcs_bad;
    assign stopped_eff = frame_start ? 1'b0 : stopped_reg;

    always_comb
    begin
        if ((len8 + 8'd1) >= HDR)
        begin
            payload = (idx8 >= HDR) && ((idx8 + FCS) < len8);
        end
        else
        begin
            payload = 1'b1;
        end
    end

    assign want_queue  = (op == OP_FRAME_BYTE) && good && payload && !stopped_eff;
    assign do_write    = cmd.accept && want_queue && !full;
    assign is_fetch_op = (op == OP_READ) || (op == OP_PEEK);
    assign status.need_fetch = is_fetch_op && !empty;

    // Next state of the ring
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        stopped_next = stopped_reg;
        qual_next    = qual_reg;
        case (op)
            OP_FRAME_BYTE:
            begin
                if (in_frame)
                begin
                    stopped_next = stopped_eff;
                    if (good)
                    begin
                        qual_next = link_quality;
                    end
                    if (want_queue)
                    begin
                        if (full)
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            wp_next = wp_inc;
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (!empty)
                begin
                    rp_next = rp_inc;
                end
            end
            OP_PEEK:
            begin
                rp_next = rp_reg;
            end
            OP_FLUSH:
            begin
                wp_next = rp_reg;
            end
            default:
            begin
                wp_next = wp_reg;
            end
        endcase
    end

    // Fill level after this item
    assign wp_wide = {1'b0, wp_next};
    assign rp_wide = {1'b0, rp_next};
    always_comb
    begin
        if (wp_wide >= rp_wide)
        begin
            fill_wide = wp_wide - rp_wide;
        end
        else
        begin
            fill_wide = wp_wide + DEPTH_CNT - rp_wide;
        end
    end

    // Commit ring state on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            stopped_reg <= 1'b0;
            qual_reg    <= '0;
        end
        else if (cmd.accept)
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            stopped_reg <= stopped_next;
            qual_reg    <= qual_next;
        end
    end

    // Load result; fill in the head byte once the ring read returns
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_data_reg  <= '0;
            res_valid_reg <= 1'b0;
            res_fill_reg  <= FILL_W'(fill_wide);
            res_qual_reg  <= qual_next;
        end
        else if (cmd.fetch_done)
        begin
            res_data_reg  <= ram_rd_data;
            res_valid_reg <= 1'b1;
        end
    end

    rpf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (wp_reg),
        .wr_data (rx_byte),
        .rd_en   (cmd.accept),
        .rd_addr (rp_reg),
        .rd_data (ram_rd_data)
    );

    assign read_data    = res_data_reg;
    assign read_valid   = res_valid_reg;
    assign fill_count   = res_fill_reg;
    assign last_quality = res_qual_reg;

endmodule

`default_nettype wire

>>> sv/rx_payload_fifo_unit.sv
`default_nettype none

// Channel   Dir  Fields
// in_ch     in   op, rx_byte, frame_length, byte_index, fcs_bad, link_quality
// out_ch    out  read_data, read_valid, fill_count, last_quality
//
// One item at a time: the result is valid the cycle after accept for a frame byte,
// a flush or a read or peek of an empty ring, and after a further fetch state for
// a read or peek that finds a byte (registered ring read port). The next item is
// taken the cycle after the result leaves; the result is held until out_ch.ready.
// in_ch.ready is high only while no item is in flight.
// Reset clears both pointers, the frame stop flag and the held link quality.

module rx_payload_fifo_unit (
    input wire logic clk,
    input wire logic rst_n,
    rpf_in_if.sink   in_ch,
    rpf_out_if.source out_ch
);

    import rpf_pkg::*;

    cmd_t    cmd;
    status_t status;

    rpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rpf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (in_ch.op),
        .rx_byte      (in_ch.rx_byte),
        .frame_length (in_ch.frame_length),
        .byte_index   (in_ch.byte_index),
        .fcs_bad      (in_ch.fcs_bad),
        .link_quality (in_ch.link_quality),
        .read_data    (out_ch.read_data),
        .read_valid   (out_ch.read_valid),
        .fill_count   (out_ch.fill_count),
        .last_quality (out_ch.last_quality)
    );

endmodule

`default_nettype wire
